>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising clk edge, suspended while rst is high.
`define CBT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cbt assertion failed");
// Check on every rising clk edge, reset included.
`define CBT_ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cbt assertion failed");
`else
`define CBT_ASSERT_RST(label, prop)
`define CBT_ASSERT_CLK(label, prop)
`endif
`endif

>>> design/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Types, constants and the fixed-point lerp shared by the tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int IDX_WIDTH   = 6;
  localparam int PROD_WIDTH  = DIFF_WIDTH + IDX_WIDTH + 1;
  localparam int LOG2_WIDTH  = 3;
  localparam int NUM_AXES    = 3;

  localparam logic [LOG2_WIDTH-1:0] MAX_LOG2   = 3'd5;
  localparam logic [LOG2_WIDTH-1:0] RESET_LOG2 = 3'd4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } in_item_t;

  typedef struct packed {
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    logic [IDX_WIDTH-1:0]   point_index;
    logic                   last_point;
  } out_item_t;

  // Per-point control that travels alongside the lane data.
  typedef struct packed {
    logic [IDX_WIDTH-1:0]  index;
    logic                  last;
    logic [LOG2_WIDTH-1:0] shift;
  } tag_t;

  // a + floor(i * (b - a) / 2^k); the result always lies between a and b.
  function automatic coord_t lerp(coord_t a, coord_t b,
                                  logic [IDX_WIDTH-1:0] i,
                                  logic [LOG2_WIDTH-1:0] k);
    logic signed [DIFF_WIDTH-1:0] d;
    logic signed [PROD_WIDTH-1:0] p;
    logic signed [PROD_WIDTH-1:0] q;
    d = $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
    p = PROD_WIDTH'(d) * PROD_WIDTH'($signed({1'b0, i}));
    q = p >>> k;
    lerp = a + coord_t'(q[COORD_WIDTH-1:0]);
  endfunction

endpackage

>>> design/cbt_lane.sv
// ----------------------------------------------------------------------------
// cbt_lane
// One axis of the de Casteljau evaluator: three lerp levels, two registered.
// ----------------------------------------------------------------------------
module cbt_lane
  import cbt_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  tag_t   tag,
  input  coord_t c0,
  input  coord_t c1,
  input  coord_t c2,
  input  coord_t c3,
  output coord_t result
);

  coord_t e;
  coord_t f;
  coord_t g;
  coord_t h;
  coord_t j;
  tag_t   tag1;
  tag_t   tag2;

  // First level: three lerps over the control polygon.
  always_ff @(posedge clk) begin
    if (en) begin
      e    <= lerp(c0, c1, tag.index, tag.shift);
      f    <= lerp(c1, c2, tag.index, tag.shift);
      g    <= lerp(c2, c3, tag.index, tag.shift);
      tag1 <= tag;
    end
  end

  // Second level.
  always_ff @(posedge clk) begin
    if (en) begin
      h    <= lerp(e, f, tag1.index, tag1.shift);
      j    <= lerp(f, g, tag1.index, tag1.shift);
      tag2 <= tag1;
    end
  end

  // Final level feeds the merge register.
  assign result = lerp(h, j, tag2.index, tag2.shift);

endmodule

>>> design/cbt_merge.sv
// ----------------------------------------------------------------------------
// cbt_merge
// Tracks point valids along the lanes and registers the merged output point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbt_merge
  import cbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      issue,
  input  tag_t      tag,
  input  coord_t    lane_result [NUM_AXES],
  input  logic      stall,
  output logic      en,
  output logic      valid,
  output out_item_t item
);

  logic v1;
  logic v2;
  tag_t tag1;
  tag_t tag2;

  // Advance the whole pipe whenever the output register can move.
  assign en = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= issue;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1             <= tag;
      tag2             <= tag1;
      item.point_x     <= lane_result[0];
      item.point_y     <= lane_result[1];
      item.point_z     <= lane_result[2];
      item.point_index <= tag2.index;
      item.last_point  <= tag2.last;
    end
  end

  `CBT_ASSERT_RST(a_last_pow2, (valid && item.last_point) |-> ($countones(item.point_index) == 1))
  `CBT_ASSERT_RST(a_pipe_fill, (v2 && en) |=> valid)
  `CBT_ASSERT_RST(a_pipe_hold, (valid && stall) |=> ($stable(v1) && $stable(v2)))

endmodule

>>> design/cubic_bezier_tessellator.sv
// Control points are stored on acceptance; each point then passes two lane
// registers and the merge register. An item gives 2^k + 1 points (17 at the
// reset value k = 4), one per cycle when not stalled; the next item is taken
// in the cycle its predecessor's last point enters the three axis lanes.
// Reset (rst, synchronous, active high): idle, no output pending, k = 4.
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator
// Uniform-parameter cubic Bezier tessellation by de Casteljau interpolation,
// one lane per axis, Q16.16 coordinates.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_bezier_tessellator
  import cbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration: segment_count_log2
  input  logic                  cfg_write,
  input  logic [LOG2_WIDTH-1:0] cfg_data,
  // control point transactions
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  // curve point transactions
  output logic                  point_valid,
  input  logic                  point_stall,
  output out_item_t             point
);

  logic [LOG2_WIDTH-1:0] seg_log2;   // configuration register
  logic [LOG2_WIDTH-1:0] k_sat;      // register value clamped to five
  logic [LOG2_WIDTH-1:0] k_run;      // k of the item in progress
  logic [IDX_WIDTH-1:0]  idx;        // next point index to issue
  logic [IDX_WIDTH-1:0]  last_idx;   // 2^k_run
  logic                  busy;
  in_item_t              store;      // control points of the current item

  logic                  en;
  logic                  issue;
  logic                  issue_last;
  logic                  accept;
  tag_t                  tag;

  coord_t                c0 [NUM_AXES];
  coord_t                c1 [NUM_AXES];
  coord_t                c2 [NUM_AXES];
  coord_t                c3 [NUM_AXES];
  coord_t                lane_result [NUM_AXES];

  // Values six and seven saturate to the 33-point case.
  assign k_sat    = (seg_log2 > MAX_LOG2) ? MAX_LOG2 : seg_log2;
  assign last_idx = IDX_WIDTH'(1) << k_run;

  // Issue one point per cycle while busy and the lanes can advance. The
  // last issue frees the store, so a new transaction may land on that edge:
  // the lanes capture the old control points at the same edge.
  assign issue      = busy && en;
  assign issue_last = issue && (idx == last_idx);
  assign item_stall = busy && !issue_last;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_log2 <= RESET_LOG2;
      busy     <= 1'b0;
      idx      <= '0;
      k_run    <= '0;
    end else begin
      if (cfg_write) begin
        seg_log2 <= cfg_data;
      end
      if (accept) begin
        busy  <= 1'b1;
        idx   <= '0;
        k_run <= k_sat;
      end else if (issue_last) begin
        busy <= 1'b0;
      end else if (issue) begin
        idx <= idx + IDX_WIDTH'(1);
      end
    end
  end

  // Capture control points on acceptance; hold them for the whole item.
  always_ff @(posedge clk) begin
    if (accept) begin
      store <= item;
    end
  end

  always_comb begin
    tag.index = idx;
    tag.last  = (idx == last_idx);
    tag.shift = k_run;
  end

  // Route each axis of the control polygon to its lane.
  always_comb begin
    c0[0] = store.p0_x;
    c0[1] = store.p0_y;
    c0[2] = store.p0_z;
    c1[0] = store.p1_x;
    c1[1] = store.p1_y;
    c1[2] = store.p1_z;
    c2[0] = store.p2_x;
    c2[1] = store.p2_y;
    c2[2] = store.p2_z;
    c3[0] = store.p3_x;
    c3[1] = store.p3_y;
    c3[2] = store.p3_z;
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    cbt_lane u_lane (
      .clk    (clk),
      .en     (en),
      .tag    (tag),
      .c0     (c0[a]),
      .c1     (c1[a]),
      .c2     (c2[a]),
      .c3     (c3[a]),
      .result (lane_result[a])
    );
  end

  // Merge the axis results into one point and hold it for the consumer.
  cbt_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .tag         (tag),
    .lane_result (lane_result),
    .stall       (point_stall),
    .en          (en),
    .valid       (point_valid),
    .item        (point)
  );

  `CBT_ASSERT_CLK(a_rst_idle, rst |=> !busy)
  `CBT_ASSERT_RST(a_accept_busy, accept |=> busy)
  `CBT_ASSERT_RST(a_idx_bound, busy |-> (idx <= last_idx))

endmodule
